[hw/rtl/hvb_pkg.sv]
// Package with the shared constants and the division tables of the brighten pipeline.
`timescale 1ns / 1ps
package hvb_pkg;

    localparam int FracBits = 16;
    localparam logic [FracBits:0] Unit = (FracBits + 1)'(1) << FracBits;

    // Reciprocal table: ceil(2^(FracBits+8) / d), zero for d = 0.
    // The ratio of two bytes is a multiplication by a table reciprocal with a
    // correction step, so no divider is built.
    localparam int RecW = FracBits + 9;

    typedef logic [255:0][RecW-1:0]     t_recip_tab;
    typedef logic [255:0][FracBits:0]   t_value_tab;

    function automatic t_recip_tab recip_tab();
        t_recip_tab tab;
        tab = '0;
        for (int d = 1; d < 256; d++) begin
            tab[d] = RecW'(((64'd1 << (FracBits + 8)) + 64'(d) - 64'd1) / 64'(d));
        end
        return tab;
    endfunction

    // Value from the maximum channel: ceil(max*Unit/255).
    function automatic t_value_tab value_tab();
        t_value_tab tab;
        tab = '0;
        for (int mx = 0; mx < 256; mx++) begin
            tab[mx] = (FracBits + 1)'((64'(mx) * (64'd1 << FracBits) + 64'd254) / 64'd255);
        end
        return tab;
    endfunction

    localparam t_recip_tab RecipTab = recip_tab();
    localparam t_value_tab ValueTab = value_tab();

    typedef struct packed {
        logic [2:0]          sext;
        logic [FracBits-1:0] frac;
        logic [FracBits:0]   sat;
        logic [FracBits:0]   val;
    } t_hsv;

endpackage

[hw/rtl/hvb_ratio.sv]
// Pipelined exact quotient floor(n * 2^FracBits / d) for bytes n <= d.
`timescale 1ns / 1ps
module hvb_ratio (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [7:0]                  i_num,
    input  logic [7:0]                  i_den,
    output logic [hvb_pkg::FracBits:0]  o_quo
);
    localparam int W = hvb_pkg::RecW + 8;

    logic [W-1:0]              r_prod;
    logic [7:0]                r_num;
    logic [7:0]                r_den;
    logic [hvb_pkg::FracBits:0] n_est;
    logic [hvb_pkg::FracBits+8:0] n_chk;
    logic [hvb_pkg::FracBits+8:0] n_tgt;

    // The rounded-up reciprocal overestimates by at most one; fix it here.
    always_comb begin
        n_est = (hvb_pkg::FracBits + 1)'(r_prod >> 8);
        n_chk = (hvb_pkg::FracBits + 9)'(n_est) * (hvb_pkg::FracBits + 9)'(r_den);
        n_tgt = (hvb_pkg::FracBits + 9)'(r_num) << hvb_pkg::FracBits;
        if (r_den == 8'd0) begin
            o_quo = '0;
        end else if (n_chk > n_tgt) begin
            o_quo = n_est - 1'b1;
        end else begin
            o_quo = n_est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= W'(i_num) * W'(hvb_pkg::RecipTab[i_den]);
            r_num  <= i_num;
            r_den  <= i_den;
        end
    end
endmodule

[hw/rtl/hvb_to_hsv.sv]
// Front half: RGB to sextant, fraction, saturation and value over two stages.
`timescale 1ns / 1ps
module hvb_to_hsv (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [7:0]      i_r,
    input  logic [7:0]      i_g,
    input  logic [7:0]      i_b,
    output hvb_pkg::t_hsv   o_hsv
);
    localparam int F = hvb_pkg::FracBits;

    logic [7:0] n_mx, n_mn, n_mag;
    logic [2:0] n_base;
    logic       n_neg;

    logic [7:0] r_mx, r_c;
    logic [2:0] r_base;
    logic       r_neg;
    logic [F:0] r_val;

    logic [F:0] w_qh, w_sat;
    logic [F+2:0] n_hue;

    always_comb begin
        if (i_r >= i_g && i_r >= i_b) begin
            n_mx = i_r; n_base = 3'd6; n_neg = i_g < i_b;
            n_mag = n_neg ? i_b - i_g : i_g - i_b;
        end else if (i_g >= i_b) begin
            n_mx = i_g; n_base = 3'd2; n_neg = i_b < i_r;
            n_mag = n_neg ? i_r - i_b : i_b - i_r;
        end else begin
            n_mx = i_b; n_base = 3'd4; n_neg = i_r < i_g;
            n_mag = n_neg ? i_g - i_r : i_r - i_g;
        end
        n_mn = (i_r < i_g) ? i_r : i_g;
        if (i_b < n_mn) begin
            n_mn = i_b;
        end
    end

    hvb_ratio u_hue (.i_clk(i_clk), .i_en(i_en), .i_num(n_mag),
                     .i_den(n_mx - n_mn), .o_quo(w_qh));
    hvb_ratio u_sat (.i_clk(i_clk), .i_en(i_en), .i_num(n_mx - n_mn),
                     .i_den(n_mx), .o_quo(w_sat));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base  <= n_base;
            r_neg   <= n_neg;
            r_c     <= n_mx - n_mn;
            r_mx    <= n_mx;
            r_val   <= hvb_pkg::ValueTab[n_mx];
        end
    end

    always_comb begin
        n_hue = (F + 3)'(r_base) << F;
        n_hue = r_neg ? n_hue - (F + 3)'(w_qh) : n_hue + (F + 3)'(w_qh);
        if (n_hue >= ((F + 3)'(6) << F)) begin
            n_hue = n_hue - ((F + 3)'(6) << F);
        end
        if (r_c == 8'd0) begin
            n_hue = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hsv.sext <= n_hue[F+2:F];
            o_hsv.frac <= n_hue[F-1:0];
            o_hsv.sat  <= (r_mx == 8'd0) ? '0 : w_sat;
            o_hsv.val  <= r_val;
        end
    end
endmodule

[hw/rtl/hvb_to_rgb.sv]
// Back half: value gain, chroma products and RGB reconstruction over four stages.
`timescale 1ns / 1ps
module hvb_to_rgb (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [15:0]     i_gain,
    input  hvb_pkg::t_hsv   i_hsv,
    output logic [7:0]      o_r,
    output logic [7:0]      o_g,
    output logic [7:0]      o_b
);
    localparam int F = hvb_pkg::FracBits;

    // Stage A: gain product.
    logic [F+16:0] r_a_vg;
    logic [F:0]    r_a_sat;
    logic [2:0]    r_a_sext;
    logic [F:0]    r_a_k;
    // Stage B: P.
    logic [2*F+1:0] r_b_vs;
    logic [F:0]    r_b_vb;
    logic [2:0]    r_b_sext;
    logic [F:0]    r_b_k;
    // Stage C: Q.
    logic [2*F+1:0] r_c_pk;
    logic [F:0]    r_c_p;
    logic [F:0]    r_c_m;
    logic [2:0]    r_c_sext;
    // Stage D: channels times 255.
    logic [F+8:0]  r_d_x [3];

    logic [F:0] n_vb, n_p, n_q;
    logic [F:0] n_ch [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_vg   <= (F + 17)'(i_hsv.val) * (F + 17)'(i_gain);
            r_a_sat  <= i_hsv.sat;
            r_a_sext <= i_hsv.sext;
            r_a_k    <= i_hsv.sext[0] ? hvb_pkg::Unit - (F + 1)'(i_hsv.frac)
                                      : (F + 1)'(i_hsv.frac);
        end
    end

    always_comb begin
        n_vb = ((r_a_vg >> 8) > (F + 17)'(hvb_pkg::Unit)) ? hvb_pkg::Unit
                                                         : (F + 1)'(r_a_vg >> 8);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_vs   <= (2 * F + 2)'(n_vb) * (2 * F + 2)'(r_a_sat);
            r_b_vb   <= n_vb;
            r_b_sext <= r_a_sext;
            r_b_k    <= r_a_k;
        end
    end

    assign n_p = (F + 1)'(r_b_vs >> F);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_pk   <= (2 * F + 2)'(n_p) * (2 * F + 2)'(r_b_k);
            r_c_p    <= n_p;
            r_c_m    <= r_b_vb - n_p;
            r_c_sext <= r_b_sext;
        end
    end

    always_comb begin
        n_q = (F + 1)'(r_c_pk >> F);
        case (r_c_sext)
            3'd0:    begin n_ch[0] = r_c_p; n_ch[1] = n_q;   n_ch[2] = '0;    end
            3'd1:    begin n_ch[0] = n_q;   n_ch[1] = r_c_p; n_ch[2] = '0;    end
            3'd2:    begin n_ch[0] = '0;    n_ch[1] = r_c_p; n_ch[2] = n_q;   end
            3'd3:    begin n_ch[0] = '0;    n_ch[1] = n_q;   n_ch[2] = r_c_p; end
            3'd4:    begin n_ch[0] = n_q;   n_ch[1] = '0;    n_ch[2] = r_c_p; end
            default: begin n_ch[0] = r_c_p; n_ch[1] = '0;    n_ch[2] = n_q;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d_x[i] <= ((F + 9)'(n_ch[i]) + (F + 9)'(r_c_m)) * (F + 9)'(255);
            end
        end
    end

    function automatic logic [7:0] sat_byte(input logic [F+8:0] x);
        return ((x >> F) > (F + 9)'(255)) ? 8'd255 : 8'(x >> F);
    endfunction

    assign o_r = sat_byte(r_d_x[0]);
    assign o_g = sat_byte(r_d_x[1]);
    assign o_b = sat_byte(r_d_x[2]);
endmodule

[hw/rtl/hsv_value_brighten_top.sv]
// Top level of the HSV value brighten pipeline with handshake and gain register.
`timescale 1ns / 1ps
// The block takes one RGB pixel per beat, converts it to HSV, scales the value
// by the Q8.8 brightness gain (saturating at full scale) and converts it back.
// It accepts one pixel every clock while the output is not stalled, and each
// result passes through the six register stages of the arithmetic pipeline.
// The whole pipeline advances together: when the output beat is stalled, the
// pipeline holds and the input is stalled too, so no beat is lost or repeated.
// The gain register is written with i_cfg_we and should change only while no
// pixel is in flight; it resets to 256, which is a gain of 1.0.
module hsv_value_brighten_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);
    localparam int Depth = 6;

    logic [15:0]      r_gain;
    logic [Depth-1:0] r_vld;
    logic             w_en;
    hvb_pkg::t_hsv    w_hsv;

    // The pipeline moves whenever the last stage is empty or being taken.
    assign w_en    = !(r_vld[Depth-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd256;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    hvb_to_hsv u_hsv (
        .i_clk(i_clk), .i_en(w_en),
        .i_r(i_red_in), .i_g(i_green_in), .i_b(i_blue_in),
        .o_hsv(w_hsv)
    );

    hvb_to_rgb u_rgb (
        .i_clk(i_clk), .i_en(w_en), .i_gain(r_gain), .i_hsv(w_hsv),
        .o_r(o_red_out), .o_g(o_green_out), .o_b(o_blue_out)
    );

`ifndef NO_ASSERTIONS
    // A stalled result beat stays valid on the next clock.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result beat dropped");
    // The input is stalled exactly when a finished beat is held back.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall)) else $error("stall mismatch");
    // An accepted pixel is captured in the first stage of the valid pipeline.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##0 1'b1 |-> ##1 r_vld[0])
        else $error("accepted beat not captured");
`endif
endmodule
